/* rtl/core/bpa_pkg.sv */
// Shared types and constants for the bitmap page allocator.
package bpa_pkg;

   localparam int unsigned WORD_BITS    = 32;
   localparam int unsigned BIT_IDX_W    = 5;
   localparam int unsigned LOW_RESERVED = 256;
   localparam int unsigned ADDR_BITS    = 32;
   localparam int unsigned COUNT_BITS   = 16;
   localparam int unsigned REQ_TDATA_W  = 40;
   localparam int unsigned RSP_TDATA_W  = 72;

   typedef enum logic [1:0] {
      OP_INIT  = 2'd0,
      OP_ALLOC = 2'd1,
      OP_FREE  = 2'd2,
      OP_NONE  = 2'd3
   } opcode_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SWEEP,
      ST_SCAN,
      ST_FREE_RD,
      ST_FREE_WR,
      ST_DONE
   } state_type;

   // Result of the shared word unit for one map word
   typedef struct packed {
      logic                 full;
      logic [BIT_IDX_W-1:0] zero_idx;
      logic [WORD_BITS-1:0] set_word;
      logic                 bit_used;
      logic [WORD_BITS-1:0] clr_word;
   } word_info_type;

endpackage

/* rtl/core/bitmap_page_allocator.sv */
// Bitmap page frame allocator, first fit, with running free page count.
//
// Requests arrive on req_* (opcode, address); every request gives exactly one
// response on rsp_* (page address, out-of-memory flag, free and used counts).
// The image end address is written through csr_wr_en/csr_wr_data and only
// read by init. One request is worked on at a time; req_tready is high only
// while idle. Work done per request before its response is loaded:
//   init  : every map word rewritten in turn (one map word rewritten per cycle)
//   alloc : from word 0 to the first word with a free bit, or the last word
//           (one word compared per cycle through the single read port and
//           the shared word unit)
//   free  : read, modify, write of one word; direct to the response when out of range
// The response sits in an output register, so a new request is taken while
// a finished response waits; a stalled receiver holds the block only when the
// next response is ready to leave.
// After reset a clearing pass zeroes the map; no request is taken meanwhile.
// Reset leaves every page free and reserves none.
module bitmap_page_allocator
   import bpa_pkg::*;
#(
   parameter int unsigned PAGE_TOTAL = 32768,
   parameter int unsigned PAGE_SHIFT = 12
) (
   input  logic                   clock,
   input  logic                   reset,
   // opcode [1:0], address [33:2], zero [39:34]
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // page_address [31:0], out_of_memory [32], free_pages [48:33],
   // used_pages [64:49], zero [71:65]
   output logic [RSP_TDATA_W-1:0] rsp_tdata,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   input  logic                   csr_wr_en,
   input  logic [ADDR_BITS-1:0]   csr_wr_data
);

   localparam int unsigned MAP_WORDS = PAGE_TOTAL / WORD_BITS;
   localparam int unsigned WADDR_W   = $clog2(MAP_WORDS);
   localparam int unsigned PTR_W     = $clog2(MAP_WORDS + 1);
   localparam int unsigned CNT_W     = $clog2(PAGE_TOTAL + 1);
   localparam int unsigned PG_W      = $clog2(PAGE_TOTAL);
   localparam int unsigned PADDR_W   = PG_W + PAGE_SHIFT;
   localparam int unsigned KSUM_W    = ADDR_BITS + 1;
   localparam int unsigned CMP_W     = (CNT_W > PTR_W) ? CNT_W : PTR_W;
   localparam logic [WADDR_W-1:0] LAST_WORD = WADDR_W'(MAP_WORDS - 1);

   state_type state_ff, state_in;

   logic [ADDR_BITS-1:0]   image_end_ff;
   logic [CNT_W-1:0]       free_cnt_ff, free_cnt_in;
   logic [CNT_W-1:0]       kp_ff, kp_in;
   logic [PTR_W-1:0]       ptr_ff, ptr_in;
   logic                   chk_vld_ff, chk_vld_in;
   logic [WADDR_W-1:0]     chk_addr_ff, chk_addr_in;
   logic [WADDR_W-1:0]     faddr_ff, faddr_in;
   logic [BIT_IDX_W-1:0]   fbit_ff, fbit_in;
   logic [ADDR_BITS-1:0]   page_ff, page_in;
   logic                   oom_ff, oom_in;
   logic                   rsp_vld_ff, rsp_vld_in;
   logic [RSP_TDATA_W-1:0] rsp_data_ff, rsp_data_in;

   opcode_type           req_op;
   logic [ADDR_BITS-1:0] req_addr;
   logic [ADDR_BITS-1:0] req_idx;
   logic                 req_fire;
   logic                 free_in_range;

   logic [KSUM_W-1:0]    ksum;
   logic [KSUM_W-1:0]    kpg;
   logic [CNT_W-1:0]     kp_clamped;

   logic                 rd_en;
   logic [WADDR_W-1:0]   rd_addr;
   logic [WORD_BITS-1:0] rd_data;
   logic                 wr_en;
   logic [WADDR_W-1:0]   wr_addr;
   logic [WORD_BITS-1:0] wr_data;
   logic [WORD_BITS-1:0] sweep_word;
   word_info_type        info;

   logic                 scan_issue;
   logic                 scan_hit;
   logic                 scan_oom;
   logic                 sweep_last;
   logic                 rsp_load;
   logic [CMP_W-1:0]     kp_word;
   logic [CMP_W-1:0]     ptr_ext;
   logic [PADDR_W-1:0]   hit_paddr;
   logic [CNT_W-1:0]     used_cnt;

   // ---------------- request decode ----------------
   assign req_op        = opcode_type'(req_tdata[1:0]);
   assign req_addr      = req_tdata[33:2];
   assign req_idx       = req_addr >> PAGE_SHIFT;
   assign free_in_range = req_idx < ADDR_BITS'(PAGE_TOTAL);
   assign req_fire      = req_tvalid && req_tready;

   // Reserved page count: ceil(image end / page size), kept in [256, PAGE_TOTAL]
   assign ksum = {1'b0, image_end_ff} + KSUM_W'((64'd1 << PAGE_SHIFT) - 64'd1);
   assign kpg  = ksum >> PAGE_SHIFT;
   always_comb begin
      if (kpg < KSUM_W'(LOW_RESERVED)) begin
         kp_clamped = CNT_W'(LOW_RESERVED);
      end else if (kpg > KSUM_W'(PAGE_TOTAL)) begin
         kp_clamped = CNT_W'(PAGE_TOTAL);
      end else begin
         kp_clamped = CNT_W'(kpg);
      end
   end

   // ---------------- datapath ----------------
   bpa_map_ram #(
      .DEPTH  (MAP_WORDS),
      .ADDR_W (WADDR_W)
   ) u_map (
      .clock   (clock),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data)
   );

   bpa_word_unit u_word (
      .word    (rd_data),
      .bit_sel (fbit_ff),
      .info    (info)
   );

   assign kp_word    = CMP_W'(kp_ff >> BIT_IDX_W);
   assign ptr_ext    = CMP_W'(ptr_ff);
   assign sweep_last = ptr_ff[WADDR_W-1:0] == LAST_WORD;
   assign scan_issue = (state_ff == ST_SCAN) && (ptr_ff < PTR_W'(MAP_WORDS));
   assign scan_hit   = (state_ff == ST_SCAN) && chk_vld_ff && !info.full;
   assign scan_oom   = (state_ff == ST_SCAN) && chk_vld_ff && info.full
                       && (chk_addr_ff == LAST_WORD);
   assign rsp_load   = (state_ff == ST_DONE) && (!rsp_vld_ff || rsp_tready);
   assign hit_paddr  = {PG_W'({chk_addr_ff, info.zero_idx}), PAGE_SHIFT'(0)};
   assign used_cnt   = CNT_W'(PAGE_TOTAL) - free_cnt_ff;

   // Init word: full below the reserved boundary, partial at it, empty above
   always_comb begin
      if (kp_word > ptr_ext) begin
         sweep_word = '1;
      end else if (kp_word == ptr_ext) begin
         sweep_word = (WORD_BITS'(1) << kp_ff[BIT_IDX_W-1:0]) - WORD_BITS'(1);
      end else begin
         sweep_word = '0;
      end
   end

   // ---------------- next state ----------------
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (sweep_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_fire) begin
               case (req_op)
                  OP_INIT:  state_in = ST_SWEEP;
                  OP_ALLOC: state_in = ST_SCAN;
                  OP_FREE:  state_in = free_in_range ? ST_FREE_RD : ST_DONE;
                  default:  state_in = ST_DONE;
               endcase
            end
         end
         ST_SWEEP: begin
            if (sweep_last) state_in = ST_DONE;
         end
         ST_SCAN: begin
            if (scan_hit || scan_oom) state_in = ST_DONE;
         end
         ST_FREE_RD: state_in = ST_FREE_WR;
         ST_FREE_WR: state_in = ST_DONE;
         ST_DONE: begin
            if (rsp_load) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // ---------------- outputs of the sequencer ----------------
   always_comb begin
      req_tready = 1'b0;
      rd_en      = 1'b0;
      rd_addr    = faddr_ff;
      wr_en      = 1'b0;
      wr_addr    = ptr_ff[WADDR_W-1:0];
      wr_data    = '0;
      case (state_ff)
         ST_CLEAR: begin
            wr_en = 1'b1;
         end
         ST_IDLE: begin
            req_tready = 1'b1;
         end
         ST_SWEEP: begin
            wr_en   = 1'b1;
            wr_data = sweep_word;
         end
         ST_SCAN: begin
            rd_en   = scan_issue;
            rd_addr = ptr_ff[WADDR_W-1:0];
            wr_en   = scan_hit;
            wr_addr = chk_addr_ff;
            wr_data = info.set_word;
         end
         ST_FREE_RD: begin
            rd_en = 1'b1;
         end
         ST_FREE_WR: begin
            wr_en   = info.bit_used;
            wr_addr = faddr_ff;
            wr_data = info.clr_word;
         end
         default: begin
         end
      endcase
   end

   // ---------------- register next values ----------------
   always_comb begin
      free_cnt_in = free_cnt_ff;
      kp_in       = kp_ff;
      ptr_in      = ptr_ff;
      chk_vld_in  = 1'b0;
      chk_addr_in = chk_addr_ff;
      faddr_in    = faddr_ff;
      fbit_in     = fbit_ff;
      page_in     = page_ff;
      oom_in      = oom_ff;
      rsp_vld_in  = rsp_vld_ff;
      rsp_data_in = rsp_data_ff;

      if (rsp_tready) rsp_vld_in = 1'b0;

      case (state_ff)
         ST_CLEAR, ST_SWEEP: begin
            ptr_in = ptr_ff + PTR_W'(1);
         end
         ST_IDLE: begin
            if (req_fire) begin
               ptr_in   = '0;
               page_in  = '0;
               oom_in   = 1'b0;
               faddr_in = req_idx[WADDR_W+BIT_IDX_W-1:BIT_IDX_W];
               fbit_in  = req_idx[BIT_IDX_W-1:0];
               if (req_op == OP_INIT) begin
                  kp_in       = kp_clamped;
                  free_cnt_in = CNT_W'(PAGE_TOTAL) - kp_clamped;
               end
            end
         end
         ST_SCAN: begin
            if (scan_issue) ptr_in = ptr_ff + PTR_W'(1);
            chk_vld_in  = scan_issue;
            chk_addr_in = ptr_ff[WADDR_W-1:0];
            if (scan_hit) begin
               chk_vld_in  = 1'b0;
               page_in     = ADDR_BITS'(hit_paddr);
               free_cnt_in = free_cnt_ff - CNT_W'(1);
            end
            if (scan_oom) begin
               oom_in = 1'b1;
            end
         end
         ST_FREE_WR: begin
            if (info.bit_used) free_cnt_in = free_cnt_ff + CNT_W'(1);
         end
         ST_DONE: begin
            if (rsp_load) begin
               rsp_vld_in  = 1'b1;
               rsp_data_in = {7'd0, COUNT_BITS'(used_cnt), COUNT_BITS'(free_cnt_ff),
                              oom_ff, page_ff};
            end
         end
         default: begin
         end
      endcase
   end

   // ---------------- registers ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         image_end_ff <= '0;
         free_cnt_ff  <= CNT_W'(PAGE_TOTAL);
         ptr_ff       <= '0;
         chk_vld_ff   <= 1'b0;
         rsp_vld_ff   <= 1'b0;
      end else begin
         state_ff    <= state_in;
         free_cnt_ff <= free_cnt_in;
         ptr_ff      <= ptr_in;
         chk_vld_ff  <= chk_vld_in;
         rsp_vld_ff  <= rsp_vld_in;
         if (csr_wr_en) image_end_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      kp_ff       <= kp_in;
      chk_addr_ff <= chk_addr_in;
      faddr_ff    <= faddr_in;
      fbit_ff     <= fbit_in;
      page_ff     <= page_in;
      oom_ff      <= oom_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

/* rtl/core/bpa_map_ram.sv */
// Used-page bitmap storage: one write port, one registered read port.
module bpa_map_ram
   import bpa_pkg::*;
#(
   parameter int unsigned DEPTH  = 1024,
   parameter int unsigned ADDR_W = 10
) (
   input  logic                 clock,
   input  logic                 rd_en,
   input  logic [ADDR_W-1:0]    rd_addr,
   output logic [WORD_BITS-1:0] rd_data,
   input  logic                 wr_en,
   input  logic [ADDR_W-1:0]    wr_addr,
   input  logic [WORD_BITS-1:0] wr_data
);

   logic [WORD_BITS-1:0] mem [DEPTH];
   logic [WORD_BITS-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/core/bpa_word_unit.sv */
// Shared word unit: lowest free bit search, bit set and bit clear on one map word.
module bpa_word_unit
   import bpa_pkg::*;
(
   input  logic [WORD_BITS-1:0] word,
   input  logic [BIT_IDX_W-1:0] bit_sel,
   output word_info_type        info
);

   logic [BIT_IDX_W-1:0] zero_idx;
   logic [WORD_BITS-1:0] sel_mask;

   // Walk downwards so the lowest clear bit wins
   always_comb begin
      zero_idx = '0;
      for (int i = WORD_BITS - 1; i >= 0; i--) begin
         if (!word[i]) begin
            zero_idx = BIT_IDX_W'(i);
         end
      end
   end

   assign sel_mask = WORD_BITS'(1) << bit_sel;

   always_comb begin
      info.full     = &word;
      info.zero_idx = zero_idx;
      info.set_word = word | (WORD_BITS'(1) << zero_idx);
      info.bit_used = |(word & sel_mask);
      info.clr_word = word & ~sel_mask;
   end

endmodule

/* verif/tb_bitmap_page_allocator.sv */
// Self-checking testbench for the bitmap page allocator: init, alloc and free traffic.
module tb_bitmap_page_allocator;
   import bpa_pkg::*;

   localparam int unsigned PAGE_TOTAL = 32768;
   localparam int unsigned PAGE_SHIFT = 12;
   localparam int unsigned MAP_WORDS  = PAGE_TOTAL / WORD_BITS;
   localparam int unsigned HOLD_LEN   = 400;
   localparam int unsigned DRAIN_LEN  = PAGE_TOTAL / WORD_BITS + 100;
   localparam int unsigned PRINT_CAP  = 100;

   typedef struct {
      opcode_type          op;
      logic [ADDR_BITS-1:0] addr;
   } page_req_type;

   typedef struct {
      logic [ADDR_BITS-1:0]  page_addr;
      logic                  oom;
      logic [COUNT_BITS-1:0] free_pages;
      logic [COUNT_BITS-1:0] used_pages;
   } page_reply_type;

   logic                   clock       = 1'b0;
   logic                   reset       = 1'b1;
   logic [REQ_TDATA_W-1:0] req_tdata   = '0;
   logic                   req_tvalid  = 1'b0;
   logic                   req_tready;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic                   rsp_tvalid;
   logic                   rsp_tready  = 1'b0;
   logic                   csr_wr_en   = 1'b0;
   logic [ADDR_BITS-1:0]   csr_wr_data = '0;

   page_req_type   pending_reqs[$];
   page_reply_type expected_replies[$];
   int unsigned error_count = 0;
   int unsigned hold_left   = 0;
   bit          steady      = 1'b0;

   // shadow of the allocator state; after reset every page is free
   logic [WORD_BITS-1:0] used_words[MAP_WORDS] = '{default: '0};
   int unsigned          free_total = PAGE_TOTAL;
   logic [ADDR_BITS-1:0] image_end_shadow = '0;

   bitmap_page_allocator #(
      .PAGE_TOTAL(PAGE_TOTAL),
      .PAGE_SHIFT(PAGE_SHIFT)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .csr_wr_en  (csr_wr_en),
      .csr_wr_data(csr_wr_data)
   );

   always #10 clock = ~clock;

   task automatic report_mismatch(string msg);
      if (error_count < PRINT_CAP) begin
         $display("MISMATCH at %0t: %s", $realtime, msg);
      end
      error_count++;
   endtask

   // pages reserved by init: ceil(image end / page size), clamped to [256, PAGE_TOTAL]
   function automatic int unsigned reserved_pages(logic [ADDR_BITS-1:0] kend);
      logic [63:0] kp;
      kp = ({32'b0, kend} + ((64'd1 << PAGE_SHIFT) - 64'd1)) >> PAGE_SHIFT;
      if (kp < LOW_RESERVED) begin
         kp = LOW_RESERVED;
      end
      if (kp > PAGE_TOTAL) begin
         kp = PAGE_TOTAL;
      end
      return int'(kp);
   endfunction

   function automatic page_reply_type predict_page_op(opcode_type op,
                                                      logic [ADDR_BITS-1:0] addr);
      page_reply_type reply;
      int unsigned kp;
      int unsigned page;
      bit          found;
      logic [63:0] wide_addr;
      reply.page_addr = '0;
      reply.oom       = 1'b0;
      found           = 1'b0;
      page            = 0;
      case (op)
         OP_INIT: begin
            kp = reserved_pages(image_end_shadow);
            foreach (used_words[w]) used_words[w] = '0;
            for (int unsigned i = 0; i < kp; i++) used_words[i / WORD_BITS][i % WORD_BITS] = 1'b1;
            free_total = PAGE_TOTAL - kp;
         end
         OP_ALLOC: begin
            for (int unsigned w = 0; w < MAP_WORDS && !found; w++) begin
               if (used_words[w] != '1) begin
                  for (int unsigned b = 0; b < WORD_BITS && !found; b++) begin
                     if (!used_words[w][b]) begin
                        page  = w * WORD_BITS + b;
                        found = 1'b1;
                     end
                  end
               end
            end
            if (found) begin
               used_words[page / WORD_BITS][page % WORD_BITS] = 1'b1;
               free_total--;
               wide_addr       = 64'(page) << PAGE_SHIFT;
               reply.page_addr = wide_addr[ADDR_BITS-1:0];
            end else begin
               reply.oom = 1'b1;
            end
         end
         OP_FREE: begin
            page = addr >> PAGE_SHIFT;
            // drop frees beyond the map, and frees of pages already free
            if (page < PAGE_TOTAL && used_words[page / WORD_BITS][page % WORD_BITS]) begin
               used_words[page / WORD_BITS][page % WORD_BITS] = 1'b0;
               free_total++;
            end
         end
         default: ;
      endcase
      reply.free_pages = free_total[COUNT_BITS-1:0];
      reply.used_pages = 16'(PAGE_TOTAL - free_total);
      return reply;
   endfunction

   // request driver: predict on each transfer, then offer the next pending item
   always @(posedge clock) begin
      page_req_type nxt;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            expected_replies.push_back(
               predict_page_op(opcode_type'(req_tdata[1:0]), req_tdata[33:2]));
         end
         if (!req_tvalid || req_tready) begin
            if (pending_reqs.size() > 0 && (steady || $urandom_range(99) >= 7)) begin
               nxt = pending_reqs.pop_front();
               req_tdata  <= {6'b0, nxt.addr, nxt.op};
               req_tvalid <= 1'b1;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // response monitor and receiver
   always @(posedge clock) begin
      page_reply_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_replies.size() == 0) begin
               report_mismatch($sformatf("response %h with nothing outstanding", rsp_tdata));
            end else begin
               want = expected_replies.pop_front();
               if (rsp_tdata[31:0] !== want.page_addr)
                  report_mismatch($sformatf("page_address got %h want %h",
                                            rsp_tdata[31:0], want.page_addr));
               if (rsp_tdata[32] !== want.oom)
                  report_mismatch($sformatf("out_of_memory got %b want %b",
                                            rsp_tdata[32], want.oom));
               if (rsp_tdata[48:33] !== want.free_pages)
                  report_mismatch($sformatf("free_pages got %0d want %0d",
                                            rsp_tdata[48:33], want.free_pages));
               if (rsp_tdata[64:49] !== want.used_pages)
                  report_mismatch($sformatf("used_pages got %0d want %0d",
                                            rsp_tdata[64:49], want.used_pages));
            end
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= steady || $urandom_range(99) >= 7;
         end
      end
   end

   task automatic push_req(opcode_type op, logic [ADDR_BITS-1:0] addr);
      page_req_type r;
      r.op   = op;
      r.addr = addr;
      pending_reqs.push_back(r);
   endtask

   task automatic wait_idle();
      do @(negedge clock);
      while (pending_reqs.size() > 0 || expected_replies.size() > 0 || req_tvalid);
   endtask

   // write the image end once everything in flight has come back
   task automatic set_image_end(logic [ADDR_BITS-1:0] value);
      wait_idle();
      @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      image_end_shadow = value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      @(negedge clock);
   endtask

   function automatic page_req_type random_req(int unsigned base);
      page_req_type r;
      int unsigned  sel;
      int unsigned  page;
      sel    = $urandom_range(99);
      r.addr = $urandom();
      if (sel < 40) begin
         r.op = OP_ALLOC;
      end else if (sel < 72) begin
         // free near the reserved boundary, hitting used and free pages alike
         page = base + $urandom_range(95);
         page = (page < 48) ? 0 : page - 48;
         if (page >= PAGE_TOTAL) page = PAGE_TOTAL - 1;
         r.op   = OP_FREE;
         r.addr = (ADDR_BITS'(page) << PAGE_SHIFT) | $urandom_range((1 << PAGE_SHIFT) - 1);
      end else if (sel < 84) begin
         r.op   = OP_FREE;
         r.addr = (ADDR_BITS'($urandom_range(PAGE_TOTAL - 1)) << PAGE_SHIFT)
                  | $urandom_range((1 << PAGE_SHIFT) - 1);
      end else if (sel < 91) begin
         r.op = OP_FREE;
      end else if (sel < 96) begin
         r.op = OP_NONE;
      end else begin
         r.op = OP_INIT;
      end
      return r;
   endfunction

   initial begin
      logic [ADDR_BITS-1:0] kend;
      int unsigned          base;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // before any init the whole map is free
      push_req(OP_ALLOC, 32'h0000_0000);
      push_req(OP_FREE,  32'h0000_0FFF);
      push_req(OP_FREE,  32'h0000_0000);
      push_req(OP_NONE,  32'hFFFF_FFFF);
      push_req(OP_FREE,  32'hFFFF_FFFF);
      push_req(OP_FREE,  32'h0800_0000);
      push_req(OP_FREE,  32'h07FF_F000);

      // image end just past page 256 rounds up to 257 reserved pages
      set_image_end(32'h0010_0001);
      push_req(OP_INIT,  32'h0000_0000);
      push_req(OP_ALLOC, 32'h0000_0000);
      push_req(OP_FREE,  32'h0000_0000);
      push_req(OP_ALLOC, 32'hFFFF_FFFF);
      push_req(OP_FREE,  32'h07FF_F123);
      push_req(OP_ALLOC, 32'h0000_0000);

      // rounding would wrap: every page reserved, alloc runs out
      set_image_end(32'hFFFF_FFFF);
      push_req(OP_INIT,  32'hFFFF_FFFF);
      push_req(OP_ALLOC, 32'h0000_0000);
      push_req(OP_FREE,  32'h07FF_F000);
      push_req(OP_ALLOC, 32'h0000_0000);
      push_req(OP_ALLOC, 32'h0000_0000);
      push_req(OP_NONE,  32'h0000_0000);

      // one page left at the top of the map
      set_image_end(32'h07FF_E001);
      push_req(OP_INIT,  32'h0000_0000);
      push_req(OP_ALLOC, 32'h0000_0000);
      push_req(OP_ALLOC, 32'h0000_0000);

      set_image_end(32'h0000_0000);
      push_req(OP_INIT,  32'h0000_0000);
      push_req(OP_ALLOC, 32'h0000_0000);

      for (int ph = 0; ph < 6; ph++) begin
         case (ph)
            0: kend = $urandom_range(32'h000F_FFFF);
            1: kend = (ADDR_BITS'($urandom_range(20000, 257)) << PAGE_SHIFT)
                      - $urandom_range((1 << PAGE_SHIFT) - 1);
            2: kend = (ADDR_BITS'(PAGE_TOTAL - $urandom_range(48, 1)) << PAGE_SHIFT)
                      + $urandom_range((1 << PAGE_SHIFT) - 1);
            3: kend = $urandom();
            4: kend = ADDR_BITS'($urandom_range(PAGE_TOTAL - 1, 256)) << PAGE_SHIFT;
            default: kend = $urandom_range(32'h00FF_FFFF);
         endcase
         set_image_end(kend);
         base   = reserved_pages(kend);
         steady = (ph == 1);
         push_req(OP_INIT, $urandom());
         for (int i = 0; i < 80; i++) pending_reqs.push_back(random_req(base));
         // stall the receiver long enough for the block to back up
         if (ph == 0) hold_left = HOLD_LEN;
      end

      wait_idle();
      steady = 1'b0;
      repeat (DRAIN_LEN) @(posedge clock);
      if (error_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

   initial begin
      #60_000_000;
      $display("Simulation FAILED");
      $finish;
   end

endmodule
